/* hw/rtl/bf16c_pkg.sv */
package bf16c_pkg;

    // Rounding mode codes of the rm field and frm
    localparam logic [2:0] RM_RNE = 3'd0;
    localparam logic [2:0] RM_RTZ = 3'd1;
    localparam logic [2:0] RM_RDN = 3'd2;
    localparam logic [2:0] RM_RUP = 3'd3;
    localparam logic [2:0] RM_RMM = 3'd4;
    localparam logic [2:0] RM_DYN = 3'd7;

    // Command codes
    localparam logic CMD_NARROW = 1'b0;
    localparam logic CMD_WIDEN  = 1'b1;

    // fflags bit positions
    localparam int FLAG_NX = 0;
    localparam int FLAG_UF = 1;
    localparam int FLAG_OF = 2;
    localparam int FLAG_DZ = 3;
    localparam int FLAG_NV = 4;

    // Canonical NaNs
    localparam logic [15:0] BF16_QNAN = 16'h7FC0;
    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;

    // Narrowing result: bf16 bits and flags
    typedef struct packed {
        logic [15:0] half;
        logic [4:0]  flags;
    } t_narrow_res;

    // Widening result: fp32 bits and flags
    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  flags;
    } t_widen_res;

    // Decide whether the truncated magnitude takes an increment
    function automatic logic rounds_up(input logic [2:0] mode, input logic neg,
                                       input logic lsb, input logic rnd,
                                       input logic stk);
        logic up;
        unique case (mode)
            RM_RNE:  up = rnd & (lsb | stk);
            RM_RDN:  up = neg & (rnd | stk);
            RM_RUP:  up = ~neg & (rnd | stk);
            RM_RMM:  up = rnd;
            default: up = 1'b0;
        endcase
        return up;
    endfunction

endpackage

/* hw/rtl/bf16_fp32_convert_unit.sv */
// Converts between fp32 and bf16 as the RISC-V Zfbfmin instructions do, one
// item per clock cycle unless the output stalls: an item is captured in
// the input register, converted by single-pass logic and held in the result
// register until taken. An illegal command (floating point off, or a bad or
// reserved rounding mode) returns illegal_trap with a zero result and flags.
// The input stalls only when both registers hold items and the output stalls.
module bf16_fp32_convert_unit
    import bf16c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [63:0] i_source_value,
    input  logic [2:0]  i_rounding_field,
    input  logic [2:0]  i_dynamic_mode,
    input  logic        i_fp_enabled,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_illegal_trap,
    output logic [63:0] o_result_value,
    output logic [4:0]  o_exception_flags
);

    logic        r_in_vld;
    logic        r_cmd;
    logic [63:0] r_src;
    logic [2:0]  r_rm;
    logic [2:0]  r_frm;
    logic        r_en;
    logic        r_out_vld;
    logic        r_trap;
    logic [63:0] r_val;
    logic [4:0]  r_flags;
    logic        n_trap;
    logic [63:0] n_val;
    logic [4:0]  n_flags;
    logic        out_ready;
    logic        in_ready;
    logic [2:0]  mode;
    t_narrow_res nar;
    t_widen_res  wid;

    // Handshake between the two register stages
    assign out_ready  = ~r_out_vld | ~i_out_stall;
    assign in_ready   = ~r_in_vld | out_ready;
    assign o_in_stall = ~in_ready;

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (in_ready && i_in_valid) begin
            r_cmd <= i_command;
            r_src <= i_source_value;
            r_rm  <= i_rounding_field;
            r_frm <= i_dynamic_mode;
            r_en  <= i_fp_enabled;
        end
    end

    // Resolve the rounding mode
    assign mode = (r_rm == RM_DYN) ? r_frm : r_rm;

    bf16c_narrow u_narrow (
        .i_source_value (r_src),
        .i_mode         (mode),
        .o_res          (nar)
    );

    bf16c_widen u_widen (
        .i_source_value (r_src),
        .o_res          (wid)
    );

    // Check legality and select the result
    always_comb begin
        n_trap  = 1'b0;
        n_val   = '0;
        n_flags = '0;
        if (!r_en) begin
            n_trap = 1'b1;
        end else if (r_cmd == CMD_NARROW) begin
            if (mode > RM_RMM) begin
                n_trap = 1'b1;
            end else begin
                n_val   = {48'hFFFF_FFFF_FFFF, nar.half};
                n_flags = nar.flags;
            end
        end else begin
            if (r_rm != RM_RNE) begin
                n_trap = 1'b1;
            end else begin
                n_val   = {32'hFFFF_FFFF, wid.word};
                n_flags = wid.flags;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_in_vld;
        end
        if (out_ready && r_in_vld) begin
            r_trap  <= n_trap;
            r_val   <= n_val;
            r_flags <= n_flags;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_illegal_trap    = r_trap;
    assign o_result_value    = r_val;
    assign o_exception_flags = r_flags;

`ifndef SYNTHESIS
    a_trap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_illegal_trap) |-> (o_result_value == 64'd0 &&
                                             o_exception_flags == 5'd0))
        else $error("trapped item carries a result");

    a_boxed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_illegal_trap) |-> (&o_result_value[63:32]))
        else $error("result is not NaN-boxed");

    a_of_nx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_exception_flags[FLAG_OF]) |-> o_exception_flags[FLAG_NX])
        else $error("overflow without inexact");

    a_no_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_exception_flags[FLAG_DZ])
        else $error("divide-by-zero flag raised");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_ready) |=> o_out_valid)
        else $error("item lost between stages");
`endif

endmodule

/* hw/rtl/bf16c_narrow.sv */
module bf16c_narrow
    import bf16c_pkg::*;
(
    input  logic [63:0]  i_source_value,
    input  logic [2:0]   i_mode,
    output t_narrow_res  o_res
);

    logic [31:0] f;
    logic        is_nan;
    logic        neg;
    logic        rnd;
    logic        stk;
    logic        lsb;
    logic [15:0] up;
    logic [7:0]  eb;
    logic [7:0]  ea;
    logic        inexact;
    logic        tiny_up;
    logic        tiny;

    // Unbox the operand; an unboxed source reads as the canonical NaN
    assign f      = (&i_source_value[63:32]) ? i_source_value[31:0] : FP32_QNAN;
    assign is_nan = (&f[30:23]) && (|f[22:0]);

    // Round the upper half
    assign neg     = f[31];
    assign rnd     = f[15];
    assign stk     = |f[14:0];
    assign lsb     = f[16];
    assign inexact = rnd | stk;
    assign up      = f[31:16] + {15'd0, rounds_up(i_mode, neg, lsb, rnd, stk)};
    assign eb      = f[30:23];
    assign ea      = up[14:7];

    // Tininess after rounding: round the subnormal mantissa with unbounded exponent
    assign tiny_up = rounds_up(i_mode, neg, f[15], f[14], |f[13:0]);
    assign tiny    = ~((&f[22:15]) & tiny_up);

    // Select result and flags
    always_comb begin
        o_res = '0;
        if (is_nan) begin
            o_res.half           = BF16_QNAN;
            o_res.flags[FLAG_NV] = ~f[22];
        end else begin
            o_res.half           = up;
            o_res.flags[FLAG_NX] = inexact;
            if ((eb != 8'hFF) && (ea == 8'hFF)) begin
                o_res.flags[FLAG_OF] = 1'b1;
                o_res.flags[FLAG_NX] = 1'b1;
            end else if (inexact && (eb == 8'd0)) begin
                o_res.flags[FLAG_UF] = tiny;
            end
        end
    end

endmodule

/* hw/rtl/bf16c_widen.sv */
module bf16c_widen
    import bf16c_pkg::*;
(
    input  logic [63:0] i_source_value,
    output t_widen_res  o_res
);

    logic        boxed;
    logic [15:0] h;
    logic        is_nan;

    assign boxed  = &i_source_value[63:16];
    assign h      = i_source_value[15:0];
    assign is_nan = (&h[14:7]) && (|h[6:0]);

    // Widen exactly, or give the canonical NaN
    always_comb begin
        o_res = '0;
        if (!boxed || is_nan) begin
            o_res.word           = FP32_QNAN;
            o_res.flags[FLAG_NV] = boxed & ~h[6];
        end else begin
            o_res.word = {h, 16'd0};
        end
    end

endmodule
